/* rtl/core/pvl_pkg.sv */
// Package for the point-light vertex lighting pipeline.
// Holds stage numbering, register codes and small arithmetic helpers.
// No dependencies.
package pvl_pkg;

  typedef logic [2:0][31:0] vec3_t;
  typedef logic [2:0][32:0] lvec3_t;

  typedef enum logic [2:0] {
    REG_LIGHT_X,
    REG_LIGHT_Y,
    REG_LIGHT_Z,
    REG_LIGHT_RED,
    REG_LIGHT_GREEN,
    REG_LIGHT_BLUE,
    REG_LIGHT_RANGE
  } cfg_reg_t;

  // iteration counts of the shift-subtract units
  localparam int NSQ_STEPS  = 17;
  localparam int LSQ_STEPS  = 32;
  localparam int NDIV_STEPS = 29;
  localparam int COS_STEPS  = 31;
  localparam int IDIV_STEPS = 32;

  // register stage numbers, stage 0 is the input register
  localparam int ST_LV   = 1;
  localparam int ST_MAG  = 2;
  localparam int ST_EXP  = 3;
  localparam int ST_SHF  = 4;
  localparam int ST_SQ   = 5;
  localparam int ST_NDIV = ST_SQ + NSQ_STEPS + 1;
  localparam int ST_PROD = ST_NDIV + NDIV_STEPS + 1;
  localparam int ST_DOT  = ST_PROD + 1;
  localparam int ST_LEN  = ST_SQ + LSQ_STEPS + 1;
  localparam int ST_CDIV = ST_DOT + 1;
  localparam int ST_COSQ = ST_CDIV + COS_STEPS + 1;
  localparam int ST_ATT  = ST_COSQ + 1;
  localparam int ST_IDIV = ST_ATT + 1;
  localparam int ST_INT  = ST_IDIV + IDIV_STEPS + 1;
  localparam int ST_SCL  = ST_INT + 1;
  localparam int ST_OUT  = ST_SCL + 1;

  localparam logic [30:0] COS_ONE = 31'h4000_0000;
  localparam logic [28:0] UNIT_Q  = 29'h1000_0000;
  localparam logic [16:0] NL_MIN  = 17'h0_8000;

  localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
  localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

  function automatic logic [4:0] msb_pos(input logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int b = 0; b < 32; b++) begin
      if (v[b]) p = 5'(b);
    end
    return p;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [49:0] v);
    logic [31:0] r;
    if (v > SAT_HI) r = 32'h7FFF_FFFF;
    else if (v < SAT_LO) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* rtl/core/point_light_vertex_lighting.sv */
// Point-light vertex lighting: adds one point light to a stream of vertex colors.
// Fixed-depth pipeline with shift-subtract square root and divider units.
// Depends on pvl_pkg.
//
//  channel   ports                          transfer
//  request   start, busy, in_*              start high while busy low
//  result    out_valid, out_*               one-cycle strobe, no backpressure
//  config    cfg_we, cfg_index, cfg_wdata   write on cfg_we
//
// One request per cycle; the pipeline depth is set by the two square roots and the
// three dividers at one bit a stage.
// busy is always low. Synchronous reset clears valid bits and the light registers.
// Results cannot be held off; the pipeline never stops.
module point_light_vertex_lighting
  import pvl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_vert_x,
  input  logic signed [31:0] in_vert_y,
  input  logic signed [31:0] in_vert_z,
  input  logic signed [31:0] in_norm_x,
  input  logic signed [31:0] in_norm_y,
  input  logic signed [31:0] in_norm_z,
  input  logic signed [31:0] in_color_in_r,
  input  logic signed [31:0] in_color_in_g,
  input  logic signed [31:0] in_color_in_b,
  output logic               out_valid,
  output logic signed [31:0] out_color_out_r,
  output logic signed [31:0] out_color_out_g,
  output logic signed [31:0] out_color_out_b,
  output logic               out_was_lit,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  vec3_t       light_pos_r;
  vec3_t       light_rgb_r;
  logic [30:0] light_range_r;

  logic [ST_OUT:0]   vld_r;
  logic [ST_OUT-1:0] kill;

  vec3_t  col_r  [0:ST_OUT-1];
  logic   byp_r  [0:ST_OUT-1];
  logic   off_r  [0:ST_OUT-1];
  vec3_t  vert_r;
  vec3_t  norm_r;

  lvec3_t      lv_r   [ST_LV:ST_PROD-1];
  logic [2:0]  nneg_r [ST_LV:ST_PROD-1];
  vec3_t       nmag_r [ST_LV:ST_EXP];
  lvec3_t      lmag_r;
  logic [31:0] amax_r;
  logic [4:0]  msb_r;
  vec3_t       tv_r;
  logic        e_r    [ST_EXP:ST_LEN-1];
  logic [2:0][15:0] nn_r [ST_SHF:ST_NDIV-1];
  logic [2:0][63:0] tsq_r;

  logic [33:0] nsq_rem_r  [0:NSQ_STEPS];
  logic [16:0] nsq_root_r [0:NSQ_STEPS];
  logic [35:0] nsq_trial  [0:NSQ_STEPS-1];
  logic [63:0] lsq_rem_r  [0:LSQ_STEPS];
  logic [31:0] lsq_root_r [0:LSQ_STEPS];
  logic [65:0] lsq_trial  [0:LSQ_STEPS-1];

  logic [2:0][17:0] nd_rem_r [0:NDIV_STEPS];
  logic [2:0][28:0] nd_q_r   [0:NDIV_STEPS];
  logic [16:0]      nd_div_r [0:NDIV_STEPS-1];
  logic [2:0][17:0] nd_sh    [0:NDIV_STEPS-1];

  logic signed [2:0][62:0] prod_r;
  logic signed [29:0]      u_s [3];
  logic signed [64:0]      dot_s;
  logic [33:0]             dp_r;
  logic [32:0]             d_r [ST_LEN:ST_INT-2];

  logic [33:0] cd_rem_r [0:COS_STEPS];
  logic [30:0] cd_q_r   [0:COS_STEPS];
  logic        cd_sat_r [0:COS_STEPS];
  logic [33:0] cd_sh    [0:COS_STEPS-1];
  logic [30:0] cos_r;
  logic [61:0] att_r;

  logic [33:0] id_rem_r [0:IDIV_STEPS];
  logic [31:0] id_q_r   [0:IDIV_STEPS];
  logic        id_sat_r [0:IDIV_STEPS];
  logic [31:0] id_low_r [0:IDIV_STEPS-1];
  logic [33:0] id_sh    [0:IDIV_STEPS-1];
  logic [31:0] int_r;
  logic [2:0][47:0] scl_r;

  logic [31:0]        rgb_mag [3];
  logic signed [49:0] col_x   [3];
  logic signed [49:0] add_x   [3];
  logic signed [49:0] sum_x   [3];
  logic               lit;

  assign busy = 1'b0;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_pos_r   <= '0;
      light_rgb_r   <= '0;
      light_range_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LIGHT_X:     light_pos_r[0] <= cfg_wdata;
        REG_LIGHT_Y:     light_pos_r[1] <= cfg_wdata;
        REG_LIGHT_Z:     light_pos_r[2] <= cfg_wdata;
        REG_LIGHT_RED:   light_rgb_r[0] <= cfg_wdata;
        REG_LIGHT_GREEN: light_rgb_r[1] <= cfg_wdata;
        REG_LIGHT_BLUE:  light_rgb_r[2] <= cfg_wdata;
        REG_LIGHT_RANGE: light_range_r  <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[ST_OUT-1:0], start & ~busy};
  end

  // kill marks an item as unlit at the stage where that becomes known
  always_comb begin
    kill          = '0;
    kill[ST_EXP]  = (amax_r == '0);
    kill[ST_LEN]  = (lsq_root_r[LSQ_STEPS] == '0);
    kill[ST_DOT]  = dot_s[64] | (dot_s == '0);
  end

  // item carry lines
  always_ff @(posedge clk) begin
    col_r[0]  <= {in_color_in_b, in_color_in_g, in_color_in_r};
    byp_r[0]  <= (light_range_r == '0);
    off_r[0]  <= kill[0];
    vert_r    <= {in_vert_z, in_vert_y, in_vert_x};
    norm_r    <= {in_norm_z, in_norm_y, in_norm_x};
    for (int k = 1; k < ST_OUT; k++) begin
      col_r[k] <= col_r[k-1];
      byp_r[k] <= byp_r[k-1];
      off_r[k] <= off_r[k-1] | kill[k];
    end
  end

  // front end: light vector, magnitudes, normalization, squares
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      lv_r[ST_LV][c] <= {light_pos_r[c][31], light_pos_r[c]} - {vert_r[c][31], vert_r[c]};
      nneg_r[ST_LV][c] <= norm_r[c][31];
      nmag_r[ST_LV][c] <= norm_r[c][31] ? 32'd0 - norm_r[c] : norm_r[c];
      lmag_r[c] <= lv_r[ST_LV][c][32] ? 33'd0 - lv_r[ST_LV][c] : lv_r[ST_LV][c];
    end
    for (int k = ST_LV + 1; k < ST_PROD; k++) begin
      lv_r[k]   <= lv_r[k-1];
      nneg_r[k] <= nneg_r[k-1];
    end
    for (int k = ST_LV + 1; k <= ST_EXP; k++) nmag_r[k] <= nmag_r[k-1];
    for (int k = ST_EXP + 1; k < ST_LEN; k++) e_r[k] <= e_r[k-1];
    for (int k = ST_SHF + 1; k < ST_NDIV; k++) nn_r[k] <= nn_r[k-1];

    if (nmag_r[ST_LV][1] > nmag_r[ST_LV][0] && nmag_r[ST_LV][1] >= nmag_r[ST_LV][2])
      amax_r <= nmag_r[ST_LV][1];
    else if (nmag_r[ST_LV][2] > nmag_r[ST_LV][0] && nmag_r[ST_LV][2] > nmag_r[ST_LV][1])
      amax_r <= nmag_r[ST_LV][2];
    else
      amax_r <= nmag_r[ST_LV][0];

    msb_r <= msb_pos(amax_r);
    e_r[ST_EXP] <= |{lmag_r[0][32:31], lmag_r[1][32:31], lmag_r[2][32:31]};
    for (int c = 0; c < 3; c++) begin
      tv_r[c] <= |{lmag_r[0][32:31], lmag_r[1][32:31], lmag_r[2][32:31]} ?
                 lmag_r[c][32:1] : lmag_r[c][31:0];
    end

    for (int c = 0; c < 3; c++) begin
      if (msb_r >= 5'd15) nn_r[ST_SHF][c] <= 16'(nmag_r[ST_EXP][c] >> (msb_r - 5'd15));
      else nn_r[ST_SHF][c] <= 16'(nmag_r[ST_EXP][c] << (5'd15 - msb_r));
      tsq_r[c] <= 64'(tv_r[c]) * 64'(tv_r[c]);
    end
  end

  // normal length square root
  always_comb begin
    for (int j = 0; j < NSQ_STEPS; j++) begin
      nsq_trial[j] = (36'(nsq_root_r[j]) << (NSQ_STEPS - j)) +
                     (36'd1 << (2 * (NSQ_STEPS - 1 - j)));
    end
  end

  always_ff @(posedge clk) begin
    nsq_rem_r[0]  <= 34'(32'(nn_r[ST_SHF][0]) * 32'(nn_r[ST_SHF][0])) +
                     34'(32'(nn_r[ST_SHF][1]) * 32'(nn_r[ST_SHF][1])) +
                     34'(32'(nn_r[ST_SHF][2]) * 32'(nn_r[ST_SHF][2]));
    nsq_root_r[0] <= '0;
    for (int j = 0; j < NSQ_STEPS; j++) begin
      if ({2'b00, nsq_rem_r[j]} >= nsq_trial[j]) begin
        nsq_rem_r[j+1]  <= nsq_rem_r[j] - nsq_trial[j][33:0];
        nsq_root_r[j+1] <= nsq_root_r[j] | (17'd1 << (NSQ_STEPS - 1 - j));
      end else begin
        nsq_rem_r[j+1]  <= nsq_rem_r[j];
        nsq_root_r[j+1] <= nsq_root_r[j];
      end
    end
  end

  // light distance square root
  always_comb begin
    for (int j = 0; j < LSQ_STEPS; j++) begin
      lsq_trial[j] = (66'(lsq_root_r[j]) << (LSQ_STEPS - j)) +
                     (66'd1 << (2 * (LSQ_STEPS - 1 - j)));
    end
  end

  always_ff @(posedge clk) begin
    lsq_rem_r[0]  <= tsq_r[0] + tsq_r[1] + tsq_r[2];
    lsq_root_r[0] <= '0;
    for (int j = 0; j < LSQ_STEPS; j++) begin
      if ({2'b00, lsq_rem_r[j]} >= lsq_trial[j]) begin
        lsq_rem_r[j+1]  <= lsq_rem_r[j] - lsq_trial[j][63:0];
        lsq_root_r[j+1] <= lsq_root_r[j] | (32'd1 << (LSQ_STEPS - 1 - j));
      end else begin
        lsq_rem_r[j+1]  <= lsq_rem_r[j];
        lsq_root_r[j+1] <= lsq_root_r[j];
      end
    end
    d_r[ST_LEN] <= e_r[ST_LEN-1] ? {lsq_root_r[LSQ_STEPS], 1'b0} :
                                   {1'b0, lsq_root_r[LSQ_STEPS]};
    for (int k = ST_LEN + 1; k < ST_INT - 1; k++) d_r[k] <= d_r[k-1];
  end

  // unit normal, three divider lanes, Q1.28
  always_comb begin
    for (int j = 0; j < NDIV_STEPS; j++) begin
      for (int c = 0; c < 3; c++) begin
        nd_sh[j][c] = (j == 0) ? nd_rem_r[j][c] : {nd_rem_r[j][c][16:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      nd_rem_r[0][c] <= 18'(nn_r[ST_NDIV-1][c]);
      nd_q_r[0][c]   <= '0;
    end
    nd_div_r[0] <= nsq_root_r[NSQ_STEPS];
    for (int j = 1; j < NDIV_STEPS; j++) nd_div_r[j] <= nd_div_r[j-1];
    for (int j = 0; j < NDIV_STEPS; j++) begin
      for (int c = 0; c < 3; c++) begin
        if (nd_sh[j][c] >= {1'b0, nd_div_r[j]}) begin
          nd_rem_r[j+1][c] <= nd_sh[j][c] - {1'b0, nd_div_r[j]};
          nd_q_r[j+1][c]   <= nd_q_r[j][c] | (29'd1 << (NDIV_STEPS - 1 - j));
        end else begin
          nd_rem_r[j+1][c] <= nd_sh[j][c];
          nd_q_r[j+1][c]   <= nd_q_r[j][c];
        end
      end
    end
  end

  // dot product of unit normal and light vector
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      u_s[c] = nneg_r[ST_PROD-1][c] ? $signed(30'd0 - {1'b0, nd_q_r[NDIV_STEPS][c]}) :
                                      $signed({1'b0, nd_q_r[NDIV_STEPS][c]});
    end
    dot_s = $signed(prod_r[0]) + $signed(prod_r[1]) + $signed(prod_r[2]);
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      prod_r[c] <= u_s[c] * $signed(lv_r[ST_PROD-1][c]);
    end
    dp_r <= dot_s[61:28];
  end

  // cosine divider, Q1.30
  always_comb begin
    for (int j = 0; j < COS_STEPS; j++) begin
      cd_sh[j] = (j == 0) ? cd_rem_r[j] : {cd_rem_r[j][32:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    cd_rem_r[0] <= dp_r;
    cd_q_r[0]   <= '0;
    cd_sat_r[0] <= {1'b0, dp_r} >= {1'b0, d_r[ST_DOT], 1'b0};
    for (int j = 0; j < COS_STEPS; j++) begin
      cd_sat_r[j+1] <= cd_sat_r[j];
      if (cd_sh[j] >= {1'b0, d_r[ST_CDIV+j]}) begin
        cd_rem_r[j+1] <= cd_sh[j] - {1'b0, d_r[ST_CDIV+j]};
        cd_q_r[j+1]   <= cd_q_r[j] | (31'd1 << (COS_STEPS - 1 - j));
      end else begin
        cd_rem_r[j+1] <= cd_sh[j];
        cd_q_r[j+1]   <= cd_q_r[j];
      end
    end
    cos_r <= (cd_sat_r[COS_STEPS] || cd_q_r[COS_STEPS] > COS_ONE) ? COS_ONE :
             cd_q_r[COS_STEPS];
    att_r <= 62'(light_range_r) * 62'(cos_r);
  end

  // intensity divider: (range * cos >> 14) / d, saturated to 32 bits
  always_comb begin
    for (int j = 0; j < IDIV_STEPS; j++) begin
      id_sh[j] = {id_rem_r[j][32:0], id_low_r[j][IDIV_STEPS-1-j]};
    end
  end

  always_ff @(posedge clk) begin
    id_rem_r[0] <= 34'(att_r[61:46]);
    id_q_r[0]   <= '0;
    id_sat_r[0] <= 33'(att_r[61:46]) >= d_r[ST_ATT];
    id_low_r[0] <= att_r[45:14];
    for (int j = 1; j < IDIV_STEPS; j++) id_low_r[j] <= id_low_r[j-1];
    for (int j = 0; j < IDIV_STEPS; j++) begin
      id_sat_r[j+1] <= id_sat_r[j];
      if (id_sh[j] >= {1'b0, d_r[ST_IDIV+j]}) begin
        id_rem_r[j+1] <= id_sh[j] - {1'b0, d_r[ST_IDIV+j]};
        id_q_r[j+1]   <= id_q_r[j] | (32'd1 << (IDIV_STEPS - 1 - j));
      end else begin
        id_rem_r[j+1] <= id_sh[j];
        id_q_r[j+1]   <= id_q_r[j];
      end
    end
    int_r <= id_sat_r[IDIV_STEPS] ? 32'hFFFF_FFFF : id_q_r[IDIV_STEPS];
  end

  // color scale and saturating add
  always_comb begin
    lit = byp_r[ST_OUT-1] | ~off_r[ST_OUT-1];
    for (int c = 0; c < 3; c++) begin
      rgb_mag[c] = light_rgb_r[c][31] ? 32'd0 - light_rgb_r[c] : light_rgb_r[c];
      col_x[c]   = {{18{col_r[ST_OUT-1][c][31]}}, col_r[ST_OUT-1][c]};
      if (byp_r[ST_OUT-1]) add_x[c] = {{18{light_rgb_r[c][31]}}, light_rgb_r[c]};
      else if (off_r[ST_OUT-1]) add_x[c] = '0;
      else if (light_rgb_r[c][31]) add_x[c] = 50'd0 - {2'b00, scl_r[c]};
      else add_x[c] = {2'b00, scl_r[c]};
      sum_x[c] = col_x[c] + add_x[c];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      scl_r[c] <= 48'((64'(rgb_mag[c]) * 64'(int_r)) >> 16);
    end
    out_color_out_r <= sat32(sum_x[0]);
    out_color_out_g <= sat32(sum_x[1]);
    out_color_out_b <= sat32(sum_x[2]);
    out_was_lit     <= lit;
  end

  assign out_valid = vld_r[ST_OUT];

  // checks
  a_out_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, ST_OUT + 1))
    else $error("result without matching request");

  a_unlit_passes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_was_lit |-> out_color_out_r == $past(in_color_in_r, ST_OUT + 1))
    else $error("unlit color changed");

  a_norm_len: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_NDIV-1] && !off_r[ST_NDIV-1] |-> nsq_root_r[NSQ_STEPS] >= NL_MIN)
    else $error("normalized normal length out of range");

  a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_PROD-1] && !off_r[ST_PROD-1] |->
      nd_q_r[NDIV_STEPS][0] <= UNIT_Q && nd_q_r[NDIV_STEPS][1] <= UNIT_Q &&
      nd_q_r[NDIV_STEPS][2] <= UNIT_Q)
    else $error("unit normal component above one");

endmodule
